// File: rtl/core/binary_cross_entropy_loss_assert.svh
// ----------------------------------------------------------------------------
// Binary cross-entropy loss assertion macros
// Implication checks on the block's clock with active-low reset
// ----------------------------------------------------------------------------
`ifndef BINARY_CROSS_ENTROPY_LOSS_ASSERT_SVH
`define BINARY_CROSS_ENTROPY_LOSS_ASSERT_SVH

// same-cycle implication
`define BCE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("bce same-cycle check failed");

// next-cycle implication
`define BCE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bce next-cycle check failed");

`endif

// File: rtl/core/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg
// Shared constants, types and the log2 mantissa table
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int COUNT_BITS     = 24;
  localparam int LOG_TABLE_BITS = 6;
  localparam int TAB_SIZE       = 1 << LOG_TABLE_BITS;

  localparam int SUM_W   = 48;
  localparam int MAG_W   = 20;
  localparam int LN_W    = 22;
  localparam int TERM_W  = 41;
  localparam int MUL_A_W = 42;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = 60;
  localparam int LOSS_W  = 37;
  localparam int DIV_W   = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic signed [LN_W-1:0]    LN_EPS_Q16 = -22'sd1810827;
  localparam logic signed [MUL_B_W-1:0] LN2_Q16    = 18'sd45426;
  localparam logic [15:0]               ONE_Q15    = 16'd32768;
  localparam logic signed [15:0]        W_ONE      = 16'sd256;

  // configuration register indexes
  localparam logic [1:0] CFG_REDUCTION = 2'd0;
  localparam logic [1:0] CFG_WEIGHT    = 2'd1;

  // reduction modes
  localparam logic [1:0] RED_NONE = 2'd0;
  localparam logic [1:0] RED_SUM  = 2'd1;

  typedef logic [15:0] log_tab_t [TAB_SIZE];

  // log2(m / 2^T) in Q16, truncated, by repeated squaring
  function automatic logic [15:0] tab_entry(input int m);
    longint unsigned z;
    logic [15:0]     r;
    z = longint'(m) << (30 - LOG_TABLE_BITS);
    r = '0;
    for (int k = 15; k >= 0; k--) begin
      z = (z * z) >> 30;
      if (z >= (64'd1 << 31)) begin
        z = z >> 1;
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic log_tab_t build_tab();
    log_tab_t t;
    for (int i = 0; i < TAB_SIZE; i++) begin
      t[i] = tab_entry(TAB_SIZE + i);
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_tab();

endpackage

// File: rtl/core/bce_log.sv
// ----------------------------------------------------------------------------
// bce_log
// Log2 magnitude of a Q1.15 value: leading-one position plus mantissa table
// ----------------------------------------------------------------------------
module bce_log (
  input  logic [15:0]              val_i,
  output logic [bce_pkg::MAG_W-1:0] mag_o
);
  import bce_pkg::*;

  logic [3:0]                pos;
  logic [15:0]               norm;
  logic [LOG_TABLE_BITS-1:0] idx;

  // leading-one search
  always_comb begin
    pos = '0;
    for (int i = 1; i < 16; i++) begin
      if (val_i[i]) pos = 4'(i);
    end
  end

  // normalise and pick mantissa index
  assign norm = val_i << (4'd15 - pos);
  assign idx  = norm[14 -: LOG_TABLE_BITS];

  // (15 - p) * 2^16 - table entry
  assign mag_o = {MAG_W'(4'd15 - pos) << 16} - MAG_W'(LOG_TAB[idx]);

endmodule

// File: rtl/core/bce_div.sv
// ----------------------------------------------------------------------------
// bce_div
// Restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bce_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bce_pkg::DIV_W-1:0]      dividend_i,
  input  logic [bce_pkg::COUNT_BITS-1:0] divisor_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [bce_pkg::DIV_W-1:0]      quotient_o
);
  import bce_pkg::*;

  logic [DIV_W-1:0]      quo_q, quo_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d, dvs_q;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  // trial subtract of the shifted remainder
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? COUNT_BITS'(trial - {1'b0, dvs_q}) : trial[COUNT_BITS-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/core/binary_cross_entropy_loss.sv
// ----------------------------------------------------------------------------
// binary_cross_entropy_loss
// Fixed-point binary cross-entropy over a stream, with none/sum/mean reduction
// ----------------------------------------------------------------------------
// Usage: a word (prob, target_value, elem_weight, last_elem) is taken when
// in_valid_i is high and in_stall_o is low. Results leave on the output
// channel (loss_value_o, range_error_o) when out_valid_o is high and
// out_stall_i is low. Registers are written through cfg_valid_i/cfg_ready_o
// (index 0 reduction mode, index 1 weight enable); the user must write them
// only while the block is idle, which the block itself does not enforce.
// Each word passes through one shared 42x18 multiplier and one log unit in
// steps (two logs, two target products, term sum, weight product,
// accumulate). A word that gives a result then takes the output step, and
// the next word is taken once the sequencer is back in idle, as after a
// word that gives none. In mean mode the last word also runs the divider,
// one quotient bit a cycle, before the output step.
// In none mode every word gives a result; in sum and mean modes only the
// word marked last does. The output register holds a result while the
// receiver stalls, and the sequencer waits in its output step until it is
// free. Reset clears the sum, count, error flag and configuration.
// ----------------------------------------------------------------------------
module binary_cross_entropy_loss (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic [1:0]                         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [15:0]                        prob_i,
  input  logic [15:0]                        target_value_i,
  input  logic signed [15:0]                 elem_weight_i,
  input  logic                               last_elem_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [bce_pkg::SUM_W-1:0]   loss_value_o,
  output logic                               range_error_o
);
  import bce_pkg::*;
  `include "binary_cross_entropy_loss_assert.svh"

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_LNX  = 10'b0000000010,
    S_LN1X = 10'b0000000100,
    S_TX   = 10'b0000001000,
    S_T1X  = 10'b0000010000,
    S_SUM  = 10'b0000100000,
    S_WGT  = 10'b0001000000,
    S_ACC  = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]  mode_q;
  logic        usew_q;
  logic [15:0] x_q, y_q;
  logic signed [15:0] w_q;
  logic        last_q;

  logic signed [LN_W-1:0]    lnx_q, ln1x_q;
  logic signed [TERM_W-1:0]  term_q;
  logic signed [MUL_P_W-1:0] prod_q;
  logic signed [SUM_W-1:0]   sum_q, res_q, out_q;
  logic [COUNT_BITS-1:0]     cnt_q;
  logic                      err_q, res_err_q, out_err_q, out_valid_q, neg_q;

  logic                      in_acc, out_free;
  logic [15:0]               log_in;
  logic [MAG_W-1:0]          log_mag;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [LN_W-1:0]    ln_now;
  logic [MAG_W+16:0]         ln_rnd;
  logic signed [LOSS_W-1:0]  loss;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_new;
  logic [COUNT_BITS-1:0]     cnt_new;
  logic [SUM_W-1:0]          sum_mag;
  logic                      div_start, div_busy, div_done;
  logic [DIV_W-1:0]          div_quo;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RED_NONE;
      usew_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_REDUCTION: mode_q <= cfg_data_i;
        CFG_WEIGHT:    usew_q <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // shared log unit: x first, then 1 - x
  assign log_in = (state_q == S_LNX) ? x_q : ONE_Q15 - x_q;

  bce_log u_log (
    .val_i (log_in),
    .mag_o (log_mag)
  );

  // ln from registered mag * ln2, rounded half up
  assign ln_rnd = prod_q[MAG_W+16:0] + (MAG_W+17)'(32768);
  assign ln_now = -LN_W'($signed({1'b0, ln_rnd[MAG_W+16:16]}));

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_LNX, S_LN1X: begin
        mul_a = MUL_A_W'($signed({1'b0, log_mag}));
        mul_b = LN2_Q16;
      end
      S_TX: begin
        mul_a = MUL_A_W'(lnx_q);
        mul_b = MUL_B_W'($signed({1'b0, y_q}));
      end
      S_T1X: begin
        mul_a = MUL_A_W'(ln1x_q);
        mul_b = MUL_B_W'($signed({1'b0, ONE_Q15}) - $signed({1'b0, y_q}));
      end
      S_WGT: begin
        mul_a = MUL_A_W'(term_q);
        mul_b = -MUL_B_W'(w_q);
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // loss rounding, accumulation with saturation
  assign loss     = LOSS_W'((prod_q + MUL_P_W'(64'sd1 << 22)) >>> 23);
  assign sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(loss);
  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
      sum_new = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      sum_new = sum_wide[SUM_W-1:0];
  end
  assign cnt_new  = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
  assign sum_mag  = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
  assign div_start = (state_q == S_ACC) & last_q & mode_q[1];

  bce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag + DIV_W'(cnt_new >> 1)),
    .divisor_i  (cnt_new),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_LNX;
      S_LNX:  state_d = S_LN1X;
      S_LN1X: state_d = S_TX;
      S_TX:   state_d = S_T1X;
      S_T1X:  state_d = S_SUM;
      S_SUM:  state_d = S_WGT;
      S_WGT:  state_d = S_ACC;
      S_ACC: begin
        if (mode_q == RED_NONE)  state_d = S_OUT;
        else if (!last_q)        state_d = S_IDLE;
        else if (mode_q[1])      state_d = S_DIV;
        else                     state_d = S_OUT;
      end
      S_DIV:  if (div_done) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && prob_i > ONE_Q15) err_q <= 1'b1;
      if (state_q == S_ACC) begin
        sum_q <= last_q ? '0 : sum_new;
        cnt_q <= last_q ? '0 : cnt_new;
        if (last_q) err_q <= 1'b0;
      end
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)            out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= (prob_i > ONE_Q15) ? ONE_Q15 : prob_i;
      y_q    <= target_value_i;
      w_q    <= usew_q ? elem_weight_i : W_ONE;
      last_q <= last_elem_i;
    end
    prod_q <= mul_p;
    if (state_q == S_LN1X) lnx_q  <= (x_q == '0) ? LN_EPS_Q16 : ln_now;
    if (state_q == S_TX)   ln1x_q <= (x_q == ONE_Q15) ? LN_EPS_Q16 : ln_now;
    if (state_q == S_T1X)  term_q <= TERM_W'(prod_q);
    if (state_q == S_SUM)  term_q <= term_q + TERM_W'(prod_q);
    if (state_q == S_ACC) begin
      res_err_q <= err_q;
      neg_q     <= sum_new[SUM_W-1];
      res_q     <= (mode_q == RED_NONE) ? SUM_W'(loss) : sum_new;
    end
    if (state_q == S_DIV && div_done)
      res_q <= neg_q ? SUM_W'(-div_quo) : SUM_W'(div_quo);
    if (state_q == S_OUT && out_free) begin
      out_q     <= res_q;
      out_err_q <= res_err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign loss_value_o  = out_q;
  assign range_error_o = out_err_q;

  // checks
  `BCE_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, in_acc, state_q == S_LNX)
  `BCE_ASSERT_IMP(a_div_idle_start, clk_i, rst_ni, div_start, !div_busy)
  `BCE_ASSERT_IMP(a_done_in_div, clk_i, rst_ni, div_done, state_q == S_DIV)
  `BCE_ASSERT_NXT(a_out_loaded, clk_i, rst_ni, state_q == S_OUT && out_free,
                  out_valid_q && state_q == S_IDLE)

endmodule
